// ===== sv/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and codes of the periodic task tick scheduler.
// Holds the operation codes, result kinds, register indexes, sequencer
// states and the per-slot task record that travels along the chain.
// ----------------------------------------------------------------------------
package ptts_pkg;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_ADD      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_SET_ACT  = 3'd3,
        OP_SET_RATE = 3'd4,
        OP_SET_USER = 3'd5,
        OP_QUERY    = 3'd6,
        OP_BAD      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        KIND_FIRE   = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    // Register indexes of the configuration port.
    localparam logic CFG_ENABLED      = 1'b0;
    localparam logic CFG_FIRST_HANDLE = 1'b1;

    // Handle given to the first added task until the register is written.
    localparam logic [15:0] FIRST_HANDLE_RESET = 16'd1;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] period;
        logic [31:0] accum;
        logic        active;
        logic [31:0] user;
    } task_rec_t;

endpackage

// ===== sv/ptts_cell.sv =====
// ----------------------------------------------------------------------------
// ptts_cell: one slot of the task ring.
// Holds one task record and loads the record handed over by its neighbor
// whenever the ring rotates or a removal shifts it.
// ----------------------------------------------------------------------------
module ptts_cell (
    input  logic                  clk,
    input  logic                  load,
    input  ptts_pkg::task_rec_t   rec_in,
    output ptts_pkg::task_rec_t   rec_out
);
    import ptts_pkg::*;

    task_rec_t rec_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule

// ===== sv/periodic_task_tick_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core: periodic task table with tick firing.
// Each request walks the task table: the task records sit in a ring of
// MAX_TASKS cells, a request rotates the ring once, looking at each record
// as it passes the head cell, and a closing step (ST_DONE) follows. busy
// is high in ST_WALK and ST_DONE, so a new request can be accepted only
// once busy is low again.
// Every result is strobed by result_valid for exactly one cycle and the
// receiver cannot stall it. Fire results trail the walk by one firing task,
// so that the final one can carry last; the final result of any request
// that gives one is on the ports in the cycle right after the closing
// step, which is the first cycle in which busy is low again.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [15:0] handle,
    input  logic [31:0] amount,
    input  logic        flag,
    input  logic signed [31:0] user_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [15:0] task_handle,
    output logic [31:0] count,
    output logic [31:0] period,
    output logic signed [31:0] user_value,
    output logic        is_active,
    output logic        ok,
    output logic        last
);
    import ptts_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] LAST_STEP  = CW'(MAX_TASKS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TASKS);

    // Request fields latched at acceptance.
    op_t         op_reg;
    logic [15:0] hdl_reg;
    logic [31:0] amt_reg;
    logic        flag_reg;
    logic [31:0] ud_reg;

    logic          enabled_reg, enabled_next;
    logic [15:0]   next_handle_reg, next_handle_next;
    logic [CW-1:0] count_reg, count_next;

    state_t        state_reg, state_next;
    logic [CW-1:0] step_reg, step_next;
    logic          found_reg, found_next;
    logic [CW-1:0] hit_pos_reg, hit_pos_next;     // slot of the matching task
    task_rec_t     found_rec_reg, found_rec_next; // its record, for a query

    // Fire result held back by one firing task.
    logic        pend_reg, pend_next;
    logic [15:0] pend_handle_reg, pend_handle_next;
    logic [31:0] pend_cnt_reg, pend_cnt_next;
    logic [31:0] pend_user_reg, pend_user_next;

    // Output registers.
    logic        rv_reg, rv_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] th_reg, th_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] per_reg, per_next;
    logic [31:0] uv_reg, uv_next;
    logic        act_reg, act_next;
    logic        ok_reg, ok_next;
    logic        last_reg, last_next;

    // Ring: cell i loads from cell i+1; the last cell loads the processed head.
    task_rec_t  ring_q [MAX_TASKS];
    task_rec_t  ring_d [MAX_TASKS];
    task_rec_t  head, head_new;
    logic [MAX_TASKS-1:0] cell_load;
    logic       walk_load;
    logic       compact;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            if (g == MAX_TASKS - 1)
            begin : g_tail
                assign ring_d[g] = head_new;
            end
            else
            begin : g_mid
                assign ring_d[g] = ring_q[g+1];
            end
            // After the walk the ring is back in place. A removal then shifts
            // every cell from the removed slot upward down by one; the tail
            // cell picks up a stale record, but it lies past the new count.
            assign cell_load[g] = walk_load || (compact && (CW'(g) >= hit_pos_reg));
            ptts_cell u_cell (
                .clk    (clk),
                .load   (cell_load[g]),
                .rec_in (ring_d[g]),
                .rec_out(ring_q[g])
            );
        end
    endgenerate

    assign head = ring_q[0];

    // At walk step s the record of slot s is at the head; it is live while
    // s is below the task count. The first live match wins, so after a
    // handle wrap the lowest slot with a duplicate handle is the one used.
    logic        live;
    logic [31:0] acc_sum;
    logic        hit;

    always_comb
    begin
        live    = (step_reg < count_reg);
        acc_sum = head.accum + amt_reg;
        hit     = live && (head.handle == hdl_reg) && !found_reg;

        head_new = head;
        state_next = state_reg;
        step_next = step_reg;
        found_next = found_reg;
        hit_pos_next = hit_pos_reg;
        found_rec_next = found_rec_reg;
        count_next = count_reg;
        next_handle_next = next_handle_reg;
        enabled_next = enabled_reg;
        pend_next = pend_reg;
        pend_handle_next = pend_handle_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_user_next = pend_user_reg;
        rv_next = 1'b0;
        kind_next = KIND_STATUS;
        th_next = '0;
        cnt_next = '0;
        per_next = '0;
        uv_next = '0;
        act_next = 1'b0;
        ok_next = 1'b0;
        last_next = 1'b0;
        walk_load = 1'b0;
        compact = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    step_next = '0;
                    found_next = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                walk_load = 1'b1;
                if (live)
                begin
                    if (op_reg == OP_TICK && enabled_reg && head.active)
                    begin
                        head_new.accum = acc_sum;
                        if (acc_sum >= head.period)
                        begin
                            // The period is taken off once; a zero period
                            // fires on every tick and leaves the sum alone.
                            head_new.accum = acc_sum - head.period;
                            pend_next = 1'b1;
                            pend_handle_next = head.handle;
                            pend_cnt_next = acc_sum;
                            pend_user_next = head.user;
                            if (pend_reg)
                            begin
                                // Another fire follows, so the held one is
                                // not the last.
                                rv_next   = 1'b1;
                                kind_next = KIND_FIRE;
                                th_next   = pend_handle_reg;
                                cnt_next  = pend_cnt_reg;
                                uv_next   = pend_user_reg;
                                ok_next   = 1'b1;
                            end
                        end
                    end
                    if (hit)
                    begin
                        found_next = 1'b1;
                        hit_pos_next = step_reg;
                        found_rec_next = head;
                        case (op_reg)
                            OP_SET_ACT:  head_new.active = flag_reg;
                            OP_SET_RATE: head_new.period = amt_reg;
                            OP_SET_USER: head_new.user   = ud_reg;
                            default:     ;
                        endcase
                    end
                end
                else if (step_reg == count_reg && op_reg == OP_ADD
                         && count_reg < FULL_COUNT)
                begin
                    // The first free slot takes the new, inactive task.
                    head_new.handle = next_handle_reg;
                    head_new.period = amt_reg;
                    head_new.accum  = '0;
                    head_new.active = 1'b0;
                    head_new.user   = ud_reg;
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
                pend_next = 1'b0;
                compact = (op_reg == OP_REMOVE) && found_reg;
                case (op_reg)
                    OP_TICK:
                    begin
                        // A tick with no firing task gives no result at all.
                        if (pend_reg)
                        begin
                            rv_next   = 1'b1;
                            last_next = 1'b1;
                            kind_next = KIND_FIRE;
                            th_next   = pend_handle_reg;
                            cnt_next  = pend_cnt_reg;
                            uv_next   = pend_user_reg;
                            ok_next   = 1'b1;
                        end
                    end
                    OP_ADD:
                    begin
                        rv_next = 1'b1;
                        last_next = 1'b1;
                        if (count_reg < FULL_COUNT)
                        begin
                            th_next = next_handle_reg;
                            ok_next = 1'b1;
                            next_handle_next = next_handle_reg + 16'd1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_BAD:
                    begin
                        rv_next = 1'b1;
                        last_next = 1'b1;
                    end
                    OP_QUERY:
                    begin
                        rv_next = 1'b1;
                        last_next = 1'b1;
                        kind_next = KIND_QUERY;
                        th_next = hdl_reg;
                        ok_next = found_reg;
                        if (found_reg)
                        begin
                            cnt_next = found_rec_reg.accum;
                            per_next = found_rec_reg.period;
                            uv_next  = found_rec_reg.user;
                            act_next = found_rec_reg.active;
                        end
                    end
                    default:
                    begin
                        rv_next = 1'b1;
                        last_next = 1'b1;
                        th_next = hdl_reg;
                        ok_next = found_reg;
                        if (op_reg == OP_REMOVE && found_reg)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                endcase
            end
            default: state_next = ST_IDLE;
        endcase

        // Register writes take effect at once; a handle write also restarts
        // the handle sequence.
        if (cfg_we)
        begin
            if (cfg_index == CFG_ENABLED)
            begin
                enabled_next = cfg_data[0];
            end
            else
            begin
                next_handle_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            enabled_reg <= 1'b0;
            next_handle_reg <= FIRST_HANDLE_RESET;
            count_reg <= '0;
            step_reg <= '0;
            found_reg <= 1'b0;
            pend_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            enabled_reg <= enabled_next;
            next_handle_reg <= next_handle_next;
            count_reg <= count_next;
            step_reg <= step_next;
            found_reg <= found_next;
            pend_reg <= pend_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            op_reg <= op_t'(op);
            hdl_reg <= handle;
            amt_reg <= amount;
            flag_reg <= flag;
            ud_reg <= user_data;
        end
        hit_pos_reg <= hit_pos_next;
        found_rec_reg <= found_rec_next;
        pend_handle_reg <= pend_handle_next;
        pend_cnt_reg <= pend_cnt_next;
        pend_user_reg <= pend_user_next;
        kind_reg <= kind_next;
        th_reg <= th_next;
        cnt_reg <= cnt_next;
        per_reg <= per_next;
        uv_reg <= uv_next;
        act_reg <= act_next;
        ok_reg <= ok_next;
        last_reg <= last_next;
    end

    assign busy = (state_reg != ST_IDLE);

    assign result_valid = rv_reg;
    assign kind = kind_reg;
    assign task_handle = th_reg;
    assign count = cnt_reg;
    assign period = per_reg;
    assign user_value = uv_reg;
    assign is_active = act_reg;
    assign ok = ok_reg;
    assign last = last_reg;

endmodule

// ===== sv/ptts_checker.sv =====
// ----------------------------------------------------------------------------
// ptts_checker: port-level checks of the scheduler core.
// Watches the command and result ports and flags protocol slips.
// ----------------------------------------------------------------------------
module ptts_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic last
);
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_valid) else $error("last without valid");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy after request");
    a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(!busy) && !busy) |-> 1'b0)
        else $error("result while idle");
endmodule

bind periodic_task_tick_scheduler_core ptts_checker u_ptts_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .last(last)
);
